@@ rtl/core/mhpq_pkg.sv @@
// types and codes shared by the max-heap priority queue
package mhpq_pkg;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic [1:0]         status;
    logic [7:0]         entry_count;
  } out_item_t;

endpackage

@@ rtl/core/max_heap_priority_queue_unit.sv @@
// binary max-heap priority queue with one shared key comparator
//
//   channel  direction  signals
//   in       input      in_valid_i, in_ready_o, in_item_i (operation, key)
//   out      output     out_valid_o, out_ready_i, out_item_o (out_key, status, entry_count)
//
// one item at a time; in_ready_o is high only while the sequencer is idle; an insert
// climbs one level per compare until a parent stops it or it reaches the root; an extract
// descends one level per compare, choosing between two children when both exist, until a
// child stops it or no child is left; rejected items go straight to the result step
// reset empties the heap at once; store contents stay undefined until written
// a result waiting on out_ready_i holds the sequencer in its last step only
module max_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = CW;
  localparam int unsigned KW = CW + 1;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_UP_RD   = 4'd1;
  localparam logic [3:0] ST_UP_CMP  = 4'd2;
  localparam logic [3:0] ST_UP_FIN  = 4'd3;
  localparam logic [3:0] ST_DN_TOP  = 4'd4;
  localparam logic [3:0] ST_DN_LAST = 4'd5;
  localparam logic [3:0] ST_DN_MOV  = 4'd6;
  localparam logic [3:0] ST_DN_RK   = 4'd7;
  localparam logic [3:0] ST_DN_RK1  = 4'd8;
  localparam logic [3:0] ST_DN_SEL  = 4'd9;
  localparam logic [3:0] ST_DN_CMP  = 4'd10;
  localparam logic [3:0] ST_DN_FIN  = 4'd11;
  localparam logic [3:0] ST_RESP    = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [KW-1:0]      kid_q, kid_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] ckey_q, ckey_d;
  logic signed [31:0] res_key_q, res_key_d;
  status_e            status_q, status_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic signed [31:0] mem [0:CAPACITY];
  logic signed [31:0] rdata_q;
  logic [AW-1:0]      mem_raddr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;

  logic signed [31:0] cmp_a, cmp_b;
  logic               cmp_gt;
  logic [CW-1:0]      pos_up;
  logic [KW-1:0]      kid_next, kid_dbl, count_ext;
  logic [31:0]        count_wide;
  logic               in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign pos_up     = pos_q >> 1;
  assign kid_next   = kid_q + KW'(1);
  assign kid_dbl    = kid_q << 1;
  assign count_ext  = KW'(count_q);
  assign count_wide = 32'(count_d);

  // shared comparator
  always_comb begin
    cmp_a = key_q;
    cmp_b = rdata_q;
    unique case (state_q)
      ST_DN_SEL: begin
        cmp_a = rdata_q;
        cmp_b = ckey_q;
      end
      ST_DN_CMP: begin
        cmp_a = ckey_q;
        cmp_b = key_q;
      end
      default: begin
        cmp_a = key_q;
        cmp_b = rdata_q;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    kid_d       = kid_q;
    key_d       = key_q;
    ckey_d      = ckey_q;
    res_key_d   = res_key_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = pos_q[AW-1:0];
    mem_wdata   = key_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d     = in_item_i.key;
          res_key_d = '0;
          status_d  = STATUS_OK;
          if (in_item_i.operation == OP_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = ST_RESP;
            end else begin
              count_d = count_q + CW'(1);
              pos_d   = count_q + CW'(1);
              state_d = (count_q == '0) ? ST_UP_FIN : ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_RESP;
            end else begin
              state_d = ST_DN_TOP;
            end
          end
        end
      end
      ST_UP_RD: begin
        mem_raddr = pos_up[AW-1:0];
        state_d   = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        if (cmp_gt) begin
          mem_wdata = rdata_q;
          pos_d     = pos_up;
          state_d   = (pos_up == CW'(1)) ? ST_UP_FIN : ST_UP_RD;
        end else begin
          mem_wdata = key_q;
          state_d   = ST_RESP;
        end
      end
      ST_UP_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = key_q;
        state_d   = ST_RESP;
      end
      ST_DN_TOP: begin
        mem_raddr = AW'(1);
        state_d   = ST_DN_LAST;
      end
      ST_DN_LAST: begin
        res_key_d = rdata_q;
        mem_raddr = count_q[AW-1:0];
        count_d   = count_q - CW'(1);
        state_d   = ST_DN_MOV;
      end
      ST_DN_MOV: begin
        key_d   = rdata_q;
        pos_d   = CW'(1);
        kid_d   = KW'(2);
        state_d = (KW'(2) > count_ext) ? ST_DN_FIN : ST_DN_RK;
      end
      ST_DN_RK: begin
        mem_raddr = kid_q[AW-1:0];
        state_d   = ST_DN_RK1;
      end
      ST_DN_RK1: begin
        ckey_d    = rdata_q;
        mem_raddr = kid_next[AW-1:0];
        state_d   = (kid_q < count_ext) ? ST_DN_SEL : ST_DN_CMP;
      end
      ST_DN_SEL: begin
        if (cmp_gt) begin
          ckey_d = rdata_q;
          kid_d  = kid_next;
        end
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        if (cmp_gt) begin
          mem_wdata = ckey_q;
          pos_d     = kid_q[CW-1:0];
          kid_d     = kid_dbl;
          state_d   = (kid_dbl > count_ext) ? ST_DN_FIN : ST_DN_RK;
        end else begin
          mem_wdata = key_q;
          state_d   = ST_RESP;
        end
      end
      ST_DN_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = key_q;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.out_key     = res_key_q;
          out_d.status      = status_q;
          out_d.entry_count = count_wide[7:0];
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    kid_q     <= kid_d;
    key_q     <= key_d;
    ckey_q    <= ckey_d;
    res_key_q <= res_key_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  // heap store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

endmodule

@@ dv/max_heap_priority_queue_checker.sv @@
// checker for the max-heap priority queue: predicts each result and compares it
module max_heap_priority_queue_checker
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        outstanding_o,
  output int        full_seen_o,
  output int        empty_seen_o,
  output int        peak_fill_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] heap_keys [CAPACITY + 1];
  int unsigned        held;
  out_item_t          pending_results [$];

  function automatic out_item_t apply_heap_op(in_item_t item);
    out_item_t          res;
    logic signed [31:0] moving;
    int unsigned        pos;
    int unsigned        hole;
    int unsigned        kid;
    res = '0;
    res.status = STATUS_OK;
    if (item.operation == OP_INSERT) begin
      if (held >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        moving = item.key;
        held++;
        pos = held;
        while (pos != 1 && moving > heap_keys[pos / 2]) begin
          heap_keys[pos] = heap_keys[pos / 2];
          pos = pos / 2;
        end
        heap_keys[pos] = moving;
      end
    end else begin
      if (held == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out_key = heap_keys[1];
        moving = heap_keys[held];
        hole = 1;
        kid = 2;
        held--;
        while (kid <= held) begin
          if (kid < held && heap_keys[kid] < heap_keys[kid + 1]) kid++;
          if (moving >= heap_keys[kid]) break;
          heap_keys[hole] = heap_keys[kid];
          hole = kid;
          kid = kid * 2;
        end
        heap_keys[hole] = moving;
      end
    end
    res.entry_count = 8'(held);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    out_item_t pred;
    if (!rst_ni) begin
      held = 0;
      pending_results.delete();
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: out_key %0d status %0d entry_count %0d",
                 out_item_i.out_key, out_item_i.status, out_item_i.entry_count);
          fail_count_o++;
        end else begin
          exp = pending_results.pop_front();
          if (out_item_i.out_key !== exp.out_key) begin
            $error("out_key mismatch: expected %0d, actual %0d", exp.out_key,
                   out_item_i.out_key);
            fail_count_o++;
          end
          if (out_item_i.status !== exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp.status,
                   out_item_i.status);
            fail_count_o++;
          end
          if (out_item_i.entry_count !== exp.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d", exp.entry_count,
                   out_item_i.entry_count);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pred = apply_heap_op(in_item_i);
        if (pred.status == STATUS_FULL) full_seen_o++;
        if (pred.status == STATUS_EMPTY) empty_seen_o++;
        if (int'(held) > peak_fill_o) peak_fill_o = held;
        pending_results.push_back(pred);
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

@@ dv/max_heap_priority_queue_unit_tb.sv @@
// testbench top for the max-heap priority queue: stimulus, flow control and verdict
module max_heap_priority_queue_unit_tb
  import mhpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = 255;
  localparam int          ITEM_TOTAL = 1300;
  localparam int          CALM_ITEMS = 200;
  localparam int          HOLD_AT    = 120;
  localparam int          LONG_HOLD  = 300;
  localparam int          DRAIN_WAIT = 64;
  localparam int          CYCLE_MAX  = 500000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int fail_count;
  int outstanding;
  int full_seen;
  int empty_seen;
  int peak_fill;

  int sent_count;
  int insert_count;
  int extract_count;
  int cycle_count;
  bit calm;
  bit held_off;

  max_heap_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  max_heap_priority_queue_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .full_seen_o  (full_seen),
    .empty_seen_o (empty_seen),
    .peak_fill_o  (peak_fill)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 4))
      0: k = $urandom_range(0, 8) - 4;
      1: k = $urandom_range(0, 1000) - 500;
      2: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh7fffffff;
          1: k = 32'sh80000000;
          2: k = 32'sd0;
          default: k = -32'sd1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic send_item(input logic op, input logic signed [31:0] key);
    in_item_t item;
    item.operation = op;
    item.key = key;
    calm = (sent_count >= ITEM_TOTAL - CALM_ITEMS);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_item_i  <= item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    if (op == OP_INSERT) insert_count++;
    else extract_count++;
    @(negedge clk_i);
  endtask

  // receiver flow control, with one long hold-off while the sender keeps offering
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && sent_count >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end
    end
  end

  initial begin
    logic op;
    int   run;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, ties, empty heap
    send_item(OP_EXTRACT, 32'sh12345678);
    send_item(OP_INSERT, 32'sh7fffffff);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sh55555555);
    send_item(OP_INSERT, 32'shaaaaaaaa);
    repeat (11) send_item(OP_EXTRACT, $urandom);

    repeat (350) begin
      op = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_EXTRACT;
      send_item(op, pick_key());
    end

    // fill past capacity, then drain past empty
    repeat (CAPACITY + 4) send_item(OP_INSERT, pick_key());
    repeat (CAPACITY + 3) send_item(OP_EXTRACT, $urandom);

    while (sent_count < ITEM_TOTAL) begin
      op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_EXTRACT;
      run = $urandom_range(1, 24);
      repeat (run) send_item(op, pick_key());
    end
    in_valid_i <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("ran %0d items (%0d inserts, %0d extracts), peak fill %0d of %0d",
             sent_count, insert_count, extract_count, peak_fill, CAPACITY);
    $display("rejected inserts on a full heap: %0d, extracts on an empty heap: %0d",
             full_seen, empty_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mhpq_pkg.sv
rtl/core/max_heap_priority_queue_unit.sv
dv/max_heap_priority_queue_checker.sv
dv/max_heap_priority_queue_unit_tb.sv
